### src/isg1d_pkg.sv
// ----------------------------------------------------------------------------
// isg1d_pkg
// Types, codes and helpers shared by the 1-D Ising spin update block.
// ----------------------------------------------------------------------------
package isg1d_pkg;

  localparam int PROB_W     = 17;
  localparam int TABLE_W    = 3 * PROB_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TABLE_W;
  localparam int SPIN_CNT_W = 11;

  typedef enum logic [1:0] {
    FUNC_SET     = 2'd0,
    FUNC_ATTEMPT = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_USE_METROPOLIS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_FROM_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_FROM_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_HEAT_BATH   = 3'd4;

  typedef struct packed {
    func_t       func;
    logic [9:0]  site;
    logic        spin_value;
    logic [15:0] rand_uniform;
  } req_t;

  typedef struct packed {
    logic               spin_after;
    logic               changed;
    logic               status;
    logic signed [11:0] magnetization;
    logic signed [11:0] bond_sum;
    logic [31:0]        accepted_count;
    logic [31:0]        attempted_count;
  } res_t;

  // Outcome of one spin update, handed from the update unit to the sequencer.
  typedef struct packed {
    logic              new_spin;
    logic              changed;
    logic              count_attempt;
    logic              count_accept;
    logic signed [2:0] delta_mag;
    logic signed [3:0] delta_bond;
  } upd_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RD_SITE,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_CALC,
    ST_DONE
  } state_t;

  // Slot 0, 1, 2 holds the entry for neighbor sum -2, 0, +2.
  function automatic logic [PROB_W-1:0] table_pick(input logic [TABLE_W-1:0] tbl,
                                                   input logic [1:0] slot);
    logic [PROB_W-1:0] p;
    unique case (slot)
      2'd0:    p = tbl[PROB_W-1:0];
      2'd1:    p = tbl[2*PROB_W-1:PROB_W];
      default: p = tbl[3*PROB_W-1:2*PROB_W];
    endcase
    return p;
  endfunction

endpackage

### src/isg1d_spin_ram.sv
// ----------------------------------------------------------------------------
// isg1d_spin_ram
// One-bit-wide spin store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module isg1d_spin_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/isg1d_update.sv
// ----------------------------------------------------------------------------
// isg1d_update
// Decides the new spin at one site and the resulting changes to the totals.
// ----------------------------------------------------------------------------
module isg1d_update import isg1d_pkg::*; (
  input  func_t              func,
  input  logic               use_metropolis,
  input  logic               old_spin,
  input  logic               left_spin,
  input  logic               right_spin,
  input  logic               spin_value,
  input  logic [15:0]        rand_uniform,
  input  logic [TABLE_W-1:0] flip_prob_from_up,
  input  logic [TABLE_W-1:0] flip_prob_from_down,
  input  logic [TABLE_W-1:0] up_prob_heat_bath,
  output upd_t               upd
);

  logic [1:0]        slot;
  logic [PROB_W-1:0] prob;
  logic              hit;
  logic              new_spin;
  logic              metro;

  // The number of up neighbors is also the table slot.
  assign slot  = {1'b0, left_spin} + {1'b0, right_spin};
  assign metro = (func == FUNC_ATTEMPT) && use_metropolis;

  always_comb begin
    if (!use_metropolis) begin
      prob = table_pick(up_prob_heat_bath, slot);
    end else if (old_spin) begin
      prob = table_pick(flip_prob_from_up, slot);
    end else begin
      prob = table_pick(flip_prob_from_down, slot);
    end
  end

  assign hit = {1'b0, rand_uniform} <= prob;

  always_comb begin
    if (func == FUNC_SET) begin
      new_spin = spin_value;
    end else if (use_metropolis) begin
      new_spin = hit ? ~old_spin : old_spin;
    end else begin
      new_spin = hit;
    end
  end

  always_comb begin
    upd.new_spin      = new_spin;
    upd.changed       = new_spin != old_spin;
    upd.count_attempt = metro;
    upd.count_accept  = metro && hit;
    upd.delta_mag     = 3'sd0;
    upd.delta_bond    = 4'sd0;
    if (new_spin != old_spin) begin
      upd.delta_mag = new_spin ? 3'sd2 : -3'sd2;
      // Bond change is 2 * new spin * neighbor sum.
      unique case (slot)
        2'd0:    upd.delta_bond = new_spin ? -4'sd4 : 4'sd4;
        2'd1:    upd.delta_bond = 4'sd0;
        default: upd.delta_bond = new_spin ? 4'sd4 : -4'sd4;
      endcase
    end
  end

endmodule

### src/ising_1d_spin_update.sv
// ----------------------------------------------------------------------------
// ising_1d_spin_update
// Ring of spins with set, single-site Metropolis or heat-bath update and
// counter clear requests; keeps magnetization and bond sum up to date.
// ----------------------------------------------------------------------------
// A set or update request steps through the read site, read left, read right,
// calc and done states, making three reads through the single spin memory read
// port; its result is loaded in done once the output is free, and only then is
// the next request taken. Clear, unused and out-of-range requests go straight to done.
// Reset and every write of spin_count start a sweep that writes +1 into each
// spin in use, one per cycle; requests wait for it.
// ----------------------------------------------------------------------------
module ising_1d_spin_update import isg1d_pkg::*; #(
  parameter int MAX_SPINS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res_data
);

  localparam int ADDR_W = (MAX_SPINS > 2) ? $clog2(MAX_SPINS) : 1;
  localparam int LEN_W  = $clog2(MAX_SPINS + 1);
  localparam int TOT_W  = LEN_W + 2;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [SPIN_CNT_W-1:0] v);
    logic [LEN_W-1:0] n;
    if (32'(v) < 32'd2) begin
      n = LEN_W'(2);
    end else if (32'(v) > 32'(MAX_SPINS)) begin
      n = LEN_W'(MAX_SPINS);
    end else begin
      n = LEN_W'(v);
    end
    return n;
  endfunction

  // Configuration registers.
  logic               use_metropolis;
  logic [LEN_W-1:0]   ring_len;
  logic [TABLE_W-1:0] flip_prob_from_up;
  logic [TABLE_W-1:0] flip_prob_from_down;
  logic [TABLE_W-1:0] up_prob_heat_bath;
  logic               len_write;
  logic [LEN_W-1:0]   len_new;

  // Sequencer and captured request.
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  sweep_idx;
  func_t              func_q;
  logic [ADDR_W-1:0]  site_q;
  logic               sval_q;
  logic [15:0]        rnd_q;
  logic               old_q;
  logic               left_q;
  logic               rs_spin;
  logic               rs_changed;
  logic               rs_status;

  // Totals and tallies.
  logic signed [TOT_W-1:0] magnet_total;
  logic signed [TOT_W-1:0] bond_total;
  logic [31:0]             accept_tally;
  logic [31:0]             attempt_tally;
  logic signed [31:0]      mag_wide;
  logic signed [31:0]      bond_wide;

  // Memory port and derived signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;
  logic [ADDR_W-1:0] left_idx;
  logic [ADDR_W-1:0] right_idx;
  logic              req_take;
  logic              site_ok;
  logic              sweep_last;
  logic              res_load;
  upd_t              upd;

  assign len_write  = cfg_we && (cfg_index == REG_SPIN_COUNT);
  assign len_new    = clamp_len(cfg_data[SPIN_CNT_W-1:0]);
  assign req_stall  = state != ST_IDLE;
  assign req_take   = req_valid && (state == ST_IDLE);
  assign site_ok    = 32'(req_data.site) < 32'(ring_len);
  assign sweep_last = (32'(sweep_idx) + 32'd1) == 32'(ring_len);
  assign res_load   = (state == ST_DONE) && (!res_valid || !res_stall);
  assign left_idx   = (site_q == '0) ? ADDR_W'(ring_len - LEN_W'(1)) : site_q - ADDR_W'(1);
  assign right_idx  = ((32'(site_q) + 32'd1) == 32'(ring_len)) ? '0 : site_q + ADDR_W'(1);

  isg1d_spin_ram #(
    .DEPTH  (MAX_SPINS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // In the calc state the read data holds the right neighbor.
  isg1d_update u_update (
    .func                (func_q),
    .use_metropolis      (use_metropolis),
    .old_spin            (old_q),
    .left_spin           (left_q),
    .right_spin          (ram_rdata),
    .spin_value          (sval_q),
    .rand_uniform        (rnd_q),
    .flip_prob_from_up   (flip_prob_from_up),
    .flip_prob_from_down (flip_prob_from_down),
    .up_prob_heat_bath   (up_prob_heat_bath),
    .upd                 (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      use_metropolis      <= 1'b1;
      ring_len            <= clamp_len(SPIN_CNT_W'(1024));
      flip_prob_from_up   <= '0;
      flip_prob_from_down <= '0;
      up_prob_heat_bath   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_METROPOLIS: use_metropolis      <= cfg_data[0];
        REG_SPIN_COUNT:     ring_len            <= len_new;
        REG_FLIP_FROM_UP:   flip_prob_from_up   <= cfg_data;
        REG_FLIP_FROM_DOWN: flip_prob_from_down <= cfg_data;
        REG_UP_HEAT_BATH:   up_prob_heat_bath   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_raddr  = site_q;
    ram_we     = 1'b0;
    ram_waddr  = site_q;
    ram_wdata  = upd.new_spin;
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          if ((req_data.func == FUNC_SET || req_data.func == FUNC_ATTEMPT) && site_ok) begin
            state_next = ST_RD_SITE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD_SITE: begin
        ram_raddr  = site_q;
        state_next = ST_RD_LEFT;
      end
      ST_RD_LEFT: begin
        ram_raddr  = left_idx;
        state_next = ST_RD_RIGHT;
      end
      ST_RD_RIGHT: begin
        ram_raddr  = right_idx;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        ram_we     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // A new ring length restarts the initialization sweep.
    if (len_write) begin
      state_next = ST_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || len_write) begin
      sweep_idx <= '0;
    end else if (state == ST_SWEEP) begin
      sweep_idx <= sweep_idx + ADDR_W'(1);
    end
  end

  // Request capture and per-request result flags.
  always_ff @(posedge clk) begin
    if (req_take) begin
      func_q     <= req_data.func;
      site_q     <= ADDR_W'(req_data.site);
      sval_q     <= req_data.spin_value;
      rnd_q      <= req_data.rand_uniform;
      rs_spin    <= 1'b0;
      rs_changed <= 1'b0;
      rs_status  <= (req_data.func == FUNC_SET || req_data.func == FUNC_ATTEMPT) && !site_ok;
    end
    if (state == ST_RD_LEFT) begin
      old_q <= ram_rdata;
    end
    if (state == ST_RD_RIGHT) begin
      left_q <= ram_rdata;
    end
    if (state == ST_CALC) begin
      rs_spin    <= upd.new_spin;
      rs_changed <= upd.changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnet_total  <= TOT_W'(clamp_len(SPIN_CNT_W'(1024)));
      bond_total    <= TOT_W'(clamp_len(SPIN_CNT_W'(1024)));
      accept_tally  <= '0;
      attempt_tally <= '0;
    end else begin
      if (len_write) begin
        magnet_total <= TOT_W'(len_new);
        bond_total   <= TOT_W'(len_new);
      end else if (state == ST_CALC) begin
        magnet_total <= magnet_total + TOT_W'(upd.delta_mag);
        bond_total   <= bond_total + TOT_W'(upd.delta_bond);
      end
      if (req_take && req_data.func == FUNC_CLEAR) begin
        accept_tally  <= '0;
        attempt_tally <= '0;
      end else if (state == ST_CALC) begin
        if (upd.count_accept && accept_tally != '1) begin
          accept_tally <= accept_tally + 32'd1;
        end
        if (upd.count_attempt && attempt_tally != '1) begin
          attempt_tally <= attempt_tally + 32'd1;
        end
      end
    end
  end

  assign mag_wide  = 32'(magnet_total);
  assign bond_wide = 32'(bond_total);

  // The totals and tallies cannot move between the calc state and the load.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.spin_after      <= rs_spin;
      res_data.changed         <= rs_changed;
      res_data.status          <= rs_status;
      res_data.magnetization   <= mag_wide[11:0];
      res_data.bond_sum        <= bond_wide[11:0];
      res_data.accepted_count  <= accept_tally;
      res_data.attempted_count <= attempt_tally;
    end
  end

endmodule

### tb/tb_ising_1d_spin_update.sv
// ----------------------------------------------------------------------------
// tb_ising_1d_spin_update
// Self-checking testbench for the 1-D Ising spin update block. A predictor
// keeps its own copy of the ring, the totals, the tallies and the registers,
// and works out the result of every accepted request. Each result is checked
// field by field in order. Directed requests come first, then random phases
// with several ring lengths, both update modes and several idling patterns.
// ----------------------------------------------------------------------------
module tb_ising_1d_spin_update import isg1d_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX = 1024;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req_data = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res_data;

  ising_1d_spin_update #(.MAX_SPINS(RING_MAX)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #6 clk = ~clk;

  // Predictor state: ring contents, running totals, tallies and registers.
  bit                  spin_ring [RING_MAX];
  int                  ring_mag;
  int                  ring_bond;
  logic [31:0]         flips_accepted;
  logic [31:0]         flips_tried;
  logic                metro_mode;
  logic [10:0]         ring_size_reg;
  logic [TABLE_W-1:0]  flip_up_tbl;
  logic [TABLE_W-1:0]  flip_down_tbl;
  logic [TABLE_W-1:0]  heat_up_tbl;

  req_t pending_reqs [$];
  res_t expected_results [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   res_stall_pct = 0;
  bit   req_taken = 1'b0;

  function automatic int ring_len();
    int n;
    n = int'(ring_size_reg);
    if (n < 2) n = 2;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  function automatic void ring_fill_up();
    foreach (spin_ring[i]) spin_ring[i] = 1'b1;
    ring_mag  = ring_len();
    ring_bond = ring_len();
  endfunction

  function automatic res_t predict_spin_update(req_t r);
    res_t               res;
    int                 n;
    int                 left;
    int                 right;
    int                 nsum;
    int                 step;
    bit                 old_spin;
    bit                 new_spin;
    logic [TABLE_W-1:0] tbl;
    logic [PROB_W-1:0]  prob;
    res = '0;
    n = ring_len();
    if (r.func == FUNC_CLEAR) begin
      flips_accepted = '0;
      flips_tried    = '0;
    end else if (r.func == FUNC_SET || r.func == FUNC_ATTEMPT) begin
      if (int'(r.site) >= n) begin
        res.status = 1'b1;
      end else begin
        left     = (r.site == 0) ? n - 1 : r.site - 1;
        right    = (r.site + 1 == n) ? 0 : r.site + 1;
        old_spin = spin_ring[r.site];
        nsum     = (spin_ring[left] ? 1 : -1) + (spin_ring[right] ? 1 : -1);
        new_spin = old_spin;
        if (r.func == FUNC_SET) begin
          new_spin = r.spin_value;
        end else begin
          if (metro_mode) tbl = old_spin ? flip_up_tbl : flip_down_tbl;
          else tbl = heat_up_tbl;
          prob = tbl[PROB_W*((nsum + 2) / 2) +: PROB_W];
          if (metro_mode) begin
            if ({1'b0, r.rand_uniform} <= prob) begin
              new_spin = ~old_spin;
              if (flips_accepted != '1) flips_accepted++;
            end
            if (flips_tried != '1) flips_tried++;
          end else begin
            new_spin = ({1'b0, r.rand_uniform} <= prob);
          end
        end
        if (new_spin != old_spin) begin
          step = new_spin ? 2 : -2;
          ring_mag  += step;
          ring_bond += step * nsum;
          spin_ring[r.site] = new_spin;
        end
        res.spin_after = new_spin;
        res.changed    = (new_spin != old_spin);
      end
    end
    res.magnetization   = ring_mag[11:0];
    res.bond_sum        = ring_bond[11:0];
    res.accepted_count  = flips_accepted;
    res.attempted_count = flips_tried;
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: a new request is presented only once the current one
  // has been taken, so a stalled request holds still.
  always @(negedge clk) begin
    if (!req_valid || req_taken) begin
      req_taken = 1'b0;
      if (!rst && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_data  <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < res_stall_pct);
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_results.push_back(predict_spin_update(req_data));
        req_taken = 1'b1;
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("spin_after", want.spin_after, res_data.spin_after);
          check_field("changed", want.changed, res_data.changed);
          check_field("status", want.status, res_data.status);
          check_field("magnetization", $signed(want.magnetization),
                      $signed(res_data.magnetization));
          check_field("bond_sum", $signed(want.bond_sum), $signed(res_data.bond_sum));
          check_field("accepted_count", want.accepted_count, res_data.accepted_count);
          check_field("attempted_count", want.attempted_count, res_data.attempted_count);
        end
      end
    end
  end

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CFG_DATA_W-1:0];
  endfunction

  // Table entries lean toward the edges: zero, the saturating values and
  // plain 16-bit probabilities.
  function automatic logic [TABLE_W-1:0] rand_table();
    logic [TABLE_W-1:0] tbl;
    logic [PROB_W-1:0]  p;
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(3))
        0:       p = '0;
        1:       p = $urandom_range(1) ? 17'h1FFFF : 17'h10000;
        default: p = PROB_W'($urandom_range(65535));
      endcase
      tbl[PROB_W*s +: PROB_W] = p;
    end
    return tbl;
  endfunction

  function automatic req_t make_req(func_t f, int site, bit sval, int rnd);
    req_t r;
    r.func         = f;
    r.site         = 10'(site);
    r.spin_value   = sval;
    r.rand_uniform = 16'(rnd);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_USE_METROPOLIS: metro_mode = val[0];
      REG_SPIN_COUNT: begin
        ring_size_reg = val[10:0];
        ring_fill_up();
      end
      REG_FLIP_FROM_UP:   flip_up_tbl   = val;
      REG_FLIP_FROM_DOWN: flip_down_tbl = val;
      REG_UP_HEAT_BATH:   heat_up_tbl   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
      1: begin send_idle_pct = 45; res_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  res_stall_pct = 45; end
      default: begin send_idle_pct = 20; res_stall_pct = 20; end
    endcase
  endtask

  // Wait until every request is taken and every result is back, then let
  // the block finish its last request.
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    timeout_guard: begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int   n;
    int   pick;
    int   site;
    req_t r;

    metro_mode     = 1'b1;
    ring_size_reg  = 11'd1024;
    flip_up_tbl    = '0;
    flip_down_tbl  = '0;
    heat_up_tbl    = '0;
    flips_accepted = '0;
    flips_tried    = '0;
    ring_fill_up();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: small Metropolis ring with saturating and exact-edge entries.
    set_idling(0);
    write_reg(REG_USE_METROPOLIS, 51'd1);
    write_reg(REG_SPIN_COUNT, 51'd8);
    write_reg(REG_FLIP_FROM_UP, {17'h10000, 17'h08000, 17'h1FFFF});
    write_reg(REG_FLIP_FROM_DOWN, {17'h0FFFF, 17'h04000, 17'h00000});
    write_reg(REG_UP_HEAT_BATH, {17'h1FFFF, 17'h08000, 17'h00000});
    pending_reqs.push_back(make_req(FUNC_SET, 3, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_SET, 3, 1'b0, 65535));
    pending_reqs.push_back(make_req(FUNC_SET, 3, 1'b1, 0));
    pending_reqs.push_back(make_req(FUNC_SET, 8, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_SET, 1023, 1'b0, 65535));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 1023, 1'b1, 0));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b0, 65535));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b1, 65535));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 7, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b0, 16'h8001));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b0, 16'h8000));
    pending_reqs.push_back(make_req(FUNC_SET, 6, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 7, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_CLEAR, 1023, 1'b1, 65535));
    pending_reqs.push_back(make_req(FUNC_NONE, 1023, 1'b1, 65535));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 2, 1'b0, 0));
    drain();

    // Directed: heat-bath moves on a ring of two; a length below two clamps.
    set_idling(3);
    write_reg(REG_USE_METROPOLIS, {rand_word() & ~51'd1});
    write_reg(REG_SPIN_COUNT, 51'd1);
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b1, 0));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 1, 1'b0, 65535));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 0, 1'b0, 65535));
    pending_reqs.push_back(make_req(FUNC_SET, 1, 1'b0, 0));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 1, 1'b0, 16'h8001));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 1, 1'b0, 16'h8000));
    pending_reqs.push_back(make_req(FUNC_ATTEMPT, 2, 1'b1, 0));
    pending_reqs.push_back(make_req(FUNC_NONE, 0, 1'b0, 0));
    drain();

    // Random phases: mostly in-range attempts and sets on a live ring, with
    // some clears, unused selectors and out-of-range sites mixed in.
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      case (ph)
        0, 4:    n = 1024;
        1:       n = $urandom_range(16, 3);
        2:       n = $urandom_range(2047);
        3:       n = $urandom_range(64, 2);
        5:       n = 2;
        6:       n = $urandom_range(600, 17);
        default: n = 2047;
      endcase
      write_reg(REG_USE_METROPOLIS, rand_word());
      write_reg(REG_SPIN_COUNT, {rand_word() & ~51'h7FF} | 51'(n));
      write_reg(REG_FLIP_FROM_UP, rand_table());
      write_reg(REG_FLIP_FROM_DOWN, rand_table());
      write_reg(REG_UP_HEAT_BATH, rand_table());
      n = ring_len();
      for (int k = 0; k < 125; k++) begin
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) site = $urandom_range(1023);
        else site = $urandom_range(n - 1);
        if (pick < 55) r = make_req(FUNC_ATTEMPT, site, $urandom_range(1), $urandom_range(65535));
        else if (pick < 85) r = make_req(FUNC_SET, site, $urandom_range(1), $urandom_range(65535));
        else if (pick < 93) r = make_req(FUNC_CLEAR, site, $urandom_range(1),
                                         $urandom_range(65535));
        else r = make_req(FUNC_NONE, site, $urandom_range(1), $urandom_range(65535));
        pending_reqs.push_back(r);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
